// ----- rtl/rc4_random_generator_top_assert.svh -----
// Assertion macros shared by the RC4 random generator modules.
`ifndef RC4_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define RC4_RANDOM_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons holds too.
`define RC4RG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define RC4RG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RC4RG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RC4RG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/rc4rg_pkg.sv -----
// Shared types and constants of the RC4 random generator.
`default_nettype none

package rc4rg_pkg;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 5;

    localparam logic [1:0] MODE_RESEED = 2'd0;
    localparam logic [1:0] MODE_DRAW16 = 2'd1;
    localparam logic [1:0] MODE_DRAW32 = 2'd2;

    localparam logic [1:0] LAST_BYTE16 = 2'd1;
    localparam logic [1:0] LAST_BYTE32 = 2'd3;

    // Datapath micro-operation issued by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_WR,
        OP_KS_RD_T,
        OP_KS_RD_J,
        OP_KS_WR_K,
        OP_KS_WR_J,
        OP_BY_RD_A,
        OP_BY_RD_B,
        OP_BY_WR_I,
        OP_BY_WR_J,
        OP_BY_RD_O,
        OP_BY_OUT,
        OP_DIV_START,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT,
        ST_KS_RD_T,
        ST_KS_RD_J,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_BY_RD_A,
        ST_BY_RD_B,
        ST_BY_WR_I,
        ST_BY_WR_J,
        ST_BY_RD_O,
        ST_BY_OUT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       lim16_zero;
        logic       k_last;
        logic       byte_last;
        logic       need_div;
        logic       div_done;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/rc4_random_generator_top.sv -----
// Top level of the RC4 random generator: controller plus datapath.
`default_nettype none

// Sequence, transaction in to m_tvalid: a reseed makes 256 identity writes, then 256
//   key-schedule swaps; a draw makes one keystream byte after another, two for 16 bits and
//   four for 32 bits, then takes the remainder unless unreduced; or it draws no bytes at all.
// Throughput: one transaction at a time, each accepted once the last result is loaded; the
//   next is taken while a finished result waits for m_tready. Reset (rst_n, asynchronous,
//   active low) clears the indices and valid bits; the table reads as zeros at once.

module rc4_random_generator_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // [31:0] key_word, [63:32] limit
    input  wire [1:0]   s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    rc4rg_pkg::dp_cmd_t    cmd;
    rc4rg_pkg::dp_status_t status;

    // Sequence every table access and the divider from one state machine.
    rc4rg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the permutation, indices, assembled word and output register.
    rc4rg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// ----- rtl/rc4rg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rc4rg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/rc4rg_div.sv -----
// Restoring divider, one quotient bit per cycle, remainder only.
`default_nettype none

`include "rc4_random_generator_top_assert.svh"

module rc4rg_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [rc4rg_pkg::WORD_W-1:0]  dividend,
    input  wire [rc4rg_pkg::WORD_W-1:0]  divisor,
    output logic [rc4rg_pkg::WORD_W-1:0] remainder,
    output logic                         done
);

    logic [rc4rg_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [rc4rg_pkg::WORD_W-1:0] dvd_reg, dvd_next;
    logic [rc4rg_pkg::WORD_W-1:0] dsr_reg, dsr_next;
    logic [rc4rg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rc4rg_pkg::WORD_W:0]   trial;
    logic                         fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[rc4rg_pkg::WORD_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rc4rg_pkg::WORD_W'(trial - {1'b0, dsr_reg})
                            : trial[rc4rg_pkg::WORD_W-1:0];
            dvd_next = {dvd_reg[rc4rg_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rc4rg_pkg::CNT_W'(rc4rg_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

    `RC4RG_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < dsr_reg, "remainder not below divisor")

endmodule

`default_nettype wire

// ----- rtl/rc4rg_datapath.sv -----
// Datapath: permutation table, indices, byte assembly, divider and output register.
`default_nettype none

`include "rc4_random_generator_top_assert.svh"

module rc4rg_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire [63:0]           s_tdata,
    input  wire [1:0]            s_tuser,
    input  wire                  m_tready,
    output logic                 m_tvalid,
    output logic [31:0]          m_tdata,
    input  rc4rg_pkg::dp_cmd_t   cmd,
    output rc4rg_pkg::dp_status_t status
);

    localparam int BW = rc4rg_pkg::BYTE_W;
    localparam int AW = rc4rg_pkg::TABLE_AW;
    localparam int WW = rc4rg_pkg::WORD_W;

    logic [1:0]    mode_reg, mode_next;
    logic [WW-1:0] key_reg, key_next;
    logic [WW-1:0] limit_reg, limit_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] jj_reg, jj_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [BW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [WW-1:0] acc_reg, acc_next;
    logic [rc4rg_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic          vld_rd_reg;
    logic [WW-1:0] out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;
    logic [BW-1:0] rd_byte;
    logic [AW-1:0] sum_idx;
    logic [BW-1:0] key_byte;

    logic          div_start;
    logic [WW-1:0] div_dividend;
    logic [WW-1:0] div_divisor;
    logic [WW-1:0] div_rem;
    logic          div_done;
    logic          zero_result;

    rc4rg_ram #(
        .WIDTH (BW),
        .DEPTH (rc4rg_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rc4rg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Entries never written since reset read as zero.
    assign rd_byte  = vld_rd_reg ? ram_rdata : '0;
    assign key_byte = key_reg[{k_reg[1:0], 3'b000} +: BW];

    assign div_dividend = acc_reg;
    assign div_divisor  = (mode_reg == rc4rg_pkg::MODE_DRAW16)
                        ? {16'h0000, limit_reg[15:0]} : limit_reg;
    assign zero_result  = (mode_reg == rc4rg_pkg::MODE_RESEED)
                       || ((mode_reg != rc4rg_pkg::MODE_DRAW16)
                           && (mode_reg != rc4rg_pkg::MODE_DRAW32))
                       || ((mode_reg == rc4rg_pkg::MODE_DRAW16)
                           && (limit_reg[15:0] == 16'h0000));

    always_comb
    begin
        mode_next      = mode_reg;
        key_next       = key_reg;
        limit_next     = limit_reg;
        k_next         = k_reg;
        jj_next        = jj_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = a_reg;
        ram_raddr      = k_reg;
        sum_idx        = '0;
        div_start      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            rc4rg_pkg::OP_LOAD:
            begin
                mode_next  = s_tuser;
                key_next   = s_tdata[31:0];
                limit_next = s_tdata[63:32];
                k_next     = '0;
                jj_next    = '0;
                cnt_next   = '0;
                acc_next   = '0;
            end
            rc4rg_pkg::OP_INIT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = k_reg;
                k_next    = k_reg + 1'b1;
            end
            rc4rg_pkg::OP_KS_RD_T:
            begin
                ram_raddr = k_reg;
            end
            rc4rg_pkg::OP_KS_RD_J:
            begin
                a_next    = rd_byte;
                sum_idx   = jj_reg + rd_byte + key_byte;
                jj_next   = sum_idx;
                ram_raddr = sum_idx;
            end
            rc4rg_pkg::OP_KS_WR_K:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = rd_byte;
            end
            rc4rg_pkg::OP_KS_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = jj_reg;
                ram_wdata = a_reg;
                k_next    = k_reg + 1'b1;
                if (k_reg == AW'(rc4rg_pkg::TABLE_DEPTH - 1))
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            rc4rg_pkg::OP_BY_RD_A:
            begin
                ram_raddr = i_reg;
            end
            rc4rg_pkg::OP_BY_RD_B:
            begin
                a_next    = rd_byte;
                sum_idx   = j_reg + rd_byte;
                j_next    = sum_idx;
                ram_raddr = sum_idx;
            end
            rc4rg_pkg::OP_BY_WR_I:
            begin
                b_next    = rd_byte;
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = rd_byte;
            end
            rc4rg_pkg::OP_BY_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
            end
            rc4rg_pkg::OP_BY_RD_O:
            begin
                ram_raddr = a_reg + b_reg;
            end
            rc4rg_pkg::OP_BY_OUT:
            begin
                acc_next[{cnt_reg, 3'b000} +: BW] = rd_byte;
                cnt_next = cnt_reg + 1'b1;
                i_next   = i_reg + 1'b1;
            end
            rc4rg_pkg::OP_DIV_START:
            begin
                div_start = 1'b1;
            end
            rc4rg_pkg::OP_RESULT:
            begin
                if (zero_result)
                begin
                    out_next = '0;
                end
                else if ((mode_reg == rc4rg_pkg::MODE_DRAW32) && (limit_reg == '0))
                begin
                    out_next = acc_reg;
                end
                else
                begin
                    out_next = div_rem;
                end
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            jj_reg        <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            vld_rd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            jj_reg        <= jj_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            vld_rd_reg    <= valid_reg[ram_raddr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        limit_reg <= limit_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign status.mode       = mode_reg;
    assign status.lim16_zero = (limit_reg[15:0] == 16'h0000);
    assign status.k_last     = (k_reg == AW'(rc4rg_pkg::TABLE_DEPTH - 1));
    assign status.byte_last  = (cnt_reg == ((mode_reg == rc4rg_pkg::MODE_DRAW16)
                                ? rc4rg_pkg::LAST_BYTE16 : rc4rg_pkg::LAST_BYTE32));
    assign status.need_div   = (mode_reg == rc4rg_pkg::MODE_DRAW16) || (limit_reg != '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || m_tready;

    `RC4RG_ASSERT_NXT(a_result_loads_output, clk, rst_n, cmd.op == rc4rg_pkg::OP_RESULT, out_valid_reg, "result op did not raise m_tvalid")

endmodule

`default_nettype wire

// ----- rtl/rc4rg_ctrl.sv -----
// Controller state machine sequencing reseed, keystream draws and reduction.
`default_nettype none

`include "rc4_random_generator_top_assert.svh"

module rc4rg_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  rc4rg_pkg::dp_status_t status,
    output rc4rg_pkg::dp_cmd_t    cmd
);

    rc4rg_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc4rg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = rc4rg_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            rc4rg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = rc4rg_pkg::OP_LOAD;
                    state_next = rc4rg_pkg::ST_DISPATCH;
                end
            end
            rc4rg_pkg::ST_DISPATCH:
            begin
                if (status.mode == rc4rg_pkg::MODE_RESEED)
                begin
                    state_next = rc4rg_pkg::ST_INIT;
                end
                else if ((status.mode == rc4rg_pkg::MODE_DRAW16) && !status.lim16_zero)
                begin
                    state_next = rc4rg_pkg::ST_BY_RD_A;
                end
                else if (status.mode == rc4rg_pkg::MODE_DRAW32)
                begin
                    state_next = rc4rg_pkg::ST_BY_RD_A;
                end
                else
                begin
                    state_next = rc4rg_pkg::ST_RESULT;
                end
            end
            rc4rg_pkg::ST_INIT:
            begin
                cmd.op = rc4rg_pkg::OP_INIT_WR;
                if (status.k_last)
                begin
                    state_next = rc4rg_pkg::ST_KS_RD_T;
                end
            end
            rc4rg_pkg::ST_KS_RD_T:
            begin
                cmd.op     = rc4rg_pkg::OP_KS_RD_T;
                state_next = rc4rg_pkg::ST_KS_RD_J;
            end
            rc4rg_pkg::ST_KS_RD_J:
            begin
                cmd.op     = rc4rg_pkg::OP_KS_RD_J;
                state_next = rc4rg_pkg::ST_KS_WR_K;
            end
            rc4rg_pkg::ST_KS_WR_K:
            begin
                cmd.op     = rc4rg_pkg::OP_KS_WR_K;
                state_next = rc4rg_pkg::ST_KS_WR_J;
            end
            rc4rg_pkg::ST_KS_WR_J:
            begin
                cmd.op     = rc4rg_pkg::OP_KS_WR_J;
                state_next = status.k_last ? rc4rg_pkg::ST_RESULT : rc4rg_pkg::ST_KS_RD_T;
            end
            rc4rg_pkg::ST_BY_RD_A:
            begin
                cmd.op     = rc4rg_pkg::OP_BY_RD_A;
                state_next = rc4rg_pkg::ST_BY_RD_B;
            end
            rc4rg_pkg::ST_BY_RD_B:
            begin
                cmd.op     = rc4rg_pkg::OP_BY_RD_B;
                state_next = rc4rg_pkg::ST_BY_WR_I;
            end
            rc4rg_pkg::ST_BY_WR_I:
            begin
                cmd.op     = rc4rg_pkg::OP_BY_WR_I;
                state_next = rc4rg_pkg::ST_BY_WR_J;
            end
            rc4rg_pkg::ST_BY_WR_J:
            begin
                cmd.op     = rc4rg_pkg::OP_BY_WR_J;
                state_next = rc4rg_pkg::ST_BY_RD_O;
            end
            rc4rg_pkg::ST_BY_RD_O:
            begin
                cmd.op     = rc4rg_pkg::OP_BY_RD_O;
                state_next = rc4rg_pkg::ST_BY_OUT;
            end
            rc4rg_pkg::ST_BY_OUT:
            begin
                cmd.op = rc4rg_pkg::OP_BY_OUT;
                if (!status.byte_last)
                begin
                    state_next = rc4rg_pkg::ST_BY_RD_A;
                end
                else if (status.need_div)
                begin
                    state_next = rc4rg_pkg::ST_DIV_START;
                end
                else
                begin
                    state_next = rc4rg_pkg::ST_RESULT;
                end
            end
            rc4rg_pkg::ST_DIV_START:
            begin
                cmd.op     = rc4rg_pkg::OP_DIV_START;
                state_next = rc4rg_pkg::ST_DIV_WAIT;
            end
            rc4rg_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rc4rg_pkg::ST_RESULT;
                end
            end
            rc4rg_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = rc4rg_pkg::OP_RESULT;
                    state_next = rc4rg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4rg_pkg::ST_IDLE;
            end
        endcase
    end

    `RC4RG_ASSERT_IMP(a_result_only_when_free, clk, rst_n, cmd.op == rc4rg_pkg::OP_RESULT, status.out_free, "result issued while output register full")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the RC4 random generator: a directed table, then random items.
`default_nettype none

module tb_top;

    // The package names only the three live modes; the fourth code returns zero and leaves the state alone.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int DIRECTED_ROWS   = 20;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int IDLE_PCT        = 35;
    localparam int QUIET_FIRST     = 900;
    localparam int QUIET_LAST      = 1200;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_REPORTS     = 10;

    // One row of the directed table. known marks a row whose result is typed in.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key_word;
        logic [31:0] limit;
        logic        known;
        logic [31:0] value;
    } stim_row_t;

    // One awaited result, tagged with the number of the transaction that caused it.
    typedef struct packed {
        logic [31:0] item;
        logic [31:0] value;
    } awaited_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;      // [31:0] key_word, [63:32] limit
    logic [1:0]  s_tuser  = rc4rg_pkg::MODE_RESEED; // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] value

    // Private copy of the generator state: permutation and the two byte indices.
    logic [7:0]  sbox [0:rc4rg_pkg::TABLE_DEPTH-1];
    logic [7:0]  ks_i;
    logic [7:0]  ks_j;

    awaited_t    awaited_values[$];
    int unsigned item_no      = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    bit          quiet        = 1'b0;

    rc4_random_generator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far above the slowest correct run, reseeds and the long hold-off included.
    initial
    begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Produce one keystream byte: index_i is used first and only then advanced,
    // so the first byte after a reseed reads entry 0.
    function automatic logic [7:0] keystream_byte();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] o;
        a          = sbox[ks_i];
        ks_j       = ks_j + a;
        b          = sbox[ks_j];
        sbox[ks_i] = b;
        sbox[ks_j] = a;
        ks_i       = ks_i + 8'd1;
        o          = a + b;
        return sbox[o];
    endfunction

    // Work out the value that one transaction returns, updating the state copy.
    function automatic logic [31:0] rc4_value(input logic [1:0] mode,
                                              input logic [31:0] key_word,
                                              input logic [31:0] limit);
        logic [7:0]  key_byte [0:3];
        logic [7:0]  jj;
        logic [7:0]  t;
        logic [31:0] v;
        logic [15:0] lim16;
        v     = '0;
        lim16 = limit[15:0];
        case (mode)
            rc4rg_pkg::MODE_RESEED:
            begin
                // Key bytes are taken least significant first.
                for (int k = 0; k < 4; k++)
                    key_byte[k] = key_word[8*k +: 8];
                for (int k = 0; k < rc4rg_pkg::TABLE_DEPTH; k++)
                    sbox[k] = k[7:0];
                jj = 8'd0;
                for (int k = 0; k < rc4rg_pkg::TABLE_DEPTH; k++)
                begin
                    t        = sbox[k];
                    jj       = jj + t + key_byte[k % 4];
                    sbox[k]  = sbox[jj];
                    sbox[jj] = t;
                end
                ks_i = 8'd0;
                ks_j = 8'd0;
                return 32'd0;
            end
            rc4rg_pkg::MODE_DRAW16:
            begin
                // A zero 16-bit limit draws nothing and leaves the state alone.
                if (lim16 == 16'd0)
                    return 32'd0;
                v[7:0]  = keystream_byte();
                v[15:8] = keystream_byte();
                return v % {16'd0, lim16};
            end
            rc4rg_pkg::MODE_DRAW32:
            begin
                v[7:0]   = keystream_byte();
                v[15:8]  = keystream_byte();
                v[23:16] = keystream_byte();
                v[31:24] = keystream_byte();
                return (limit != 32'd0) ? (v % limit) : v;
            end
            default:
                return 32'd0;
        endcase
    endfunction

    // Offer one transaction, idling at random beforehand, and hold it until accepted.
    // Every call starts in the time step of the previous acceptance, so s_tvalid
    // gets a single assignment in that step: either dropped for a gap or kept high.
    task automatic send_item(input logic [1:0] mode, input logic [31:0] key_word,
                             input logic [31:0] limit, input logic known,
                             input logic [31:0] typed);
        awaited_t    entry;
        logic [31:0] predicted;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {limit, key_word};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Accepted at this edge: advance the state copy and queue the result.
        predicted   = rc4_value(mode, key_word, limit);
        entry.item  = item_no;
        entry.value = known ? typed : predicted;
        awaited_values.push_back(entry);
        item_no++;
    endtask

    // Result side: random back-pressure, one long hold-off, and the in-order check.
    initial
    begin : result_side
        awaited_t want;
        bit       held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && results_seen >= HOLD_OFF_AT)
            begin
                // Hold off long enough for a reseed to finish behind a waiting
                // result, so the block fills up and drops s_tready.
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1)
                    @(posedge clk);
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (awaited_values.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: value %h", m_tdata);
                end
                else
                begin
                    want = awaited_values.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("item %0d: value expected %h, got %h",
                                     want.item, want.value, m_tdata);
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, the random part, then drain and report.
    initial
    begin : stimulus
        stim_row_t   rows [0:DIRECTED_ROWS-1];
        logic [1:0]  mode;
        logic [31:0] key_word;
        logic [31:0] limit;
        int          pick;
        int          sent;

        // The table comes out of reset as all zeros, not as the identity.
        for (int k = 0; k < rc4rg_pkg::TABLE_DEPTH; k++)
            sbox[k] = 8'd0;
        ks_i = 8'd0;
        ks_j = 8'd0;

        // Directed table. Typed results: anything on the all-zero table, reseeds,
        // the unused mode, a zero 16-bit limit and a limit of one.
        rows[0]  = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0};
        rows[1]  = {rc4rg_pkg::MODE_DRAW16, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, 32'h0};
        rows[2]  = {MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0};
        rows[3]  = {rc4rg_pkg::MODE_RESEED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0};
        rows[4]  = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0};
        rows[5]  = {rc4rg_pkg::MODE_DRAW16, 32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0};
        rows[6]  = {rc4rg_pkg::MODE_DRAW16, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0};
        rows[7]  = {rc4rg_pkg::MODE_DRAW16, 32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0};
        rows[8]  = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0};
        rows[9]  = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0};
        rows[10] = {rc4rg_pkg::MODE_RESEED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0};
        rows[11] = {rc4rg_pkg::MODE_DRAW32, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0};
        rows[12] = {rc4rg_pkg::MODE_DRAW16, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0, 32'h0};
        rows[13] = {rc4rg_pkg::MODE_RESEED, 32'h0302_0100, 32'h5555_5555, 1'b1, 32'h0};
        rows[14] = {rc4rg_pkg::MODE_DRAW16, 32'h0000_0000, 32'hFFFF_0007, 1'b0, 32'h0};
        rows[15] = {MODE_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0};
        rows[16] = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0};
        rows[17] = {rc4rg_pkg::MODE_RESEED, 32'h8000_0001, 32'hAAAA_AAAA, 1'b1, 32'h0};
        rows[18] = {rc4rg_pkg::MODE_DRAW32, 32'h0000_0000, 32'h0000_0002, 1'b0, 32'h0};
        rows[19] = {rc4rg_pkg::MODE_DRAW16, 32'h0000_0000, 32'hFFFF_0000, 1'b1, 32'h0};

        // Hold reset low, then release it at a rising edge.
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
            send_item(rows[n].mode, rows[n].key_word, rows[n].limit,
                      rows[n].known, rows[n].value);

        // Random part: mostly draws, a few reseeds to move the permutation on,
        // and an occasional unused mode. The unused mode does not count.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (sent >= QUIET_FIRST) && (sent < QUIET_LAST);
            pick  = $urandom_range(99);
            if (pick < 4)
                mode = rc4rg_pkg::MODE_RESEED;
            else if (pick < 6)
                mode = MODE_UNUSED;
            else if (pick < 53)
                mode = rc4rg_pkg::MODE_DRAW16;
            else
                mode = rc4rg_pkg::MODE_DRAW32;
            key_word = $urandom;
            pick     = $urandom_range(9);
            case (pick)
                0:       limit = 32'd0;
                1:       limit = $urandom_range(16, 1);
                2:       limit = {16'($urandom), 16'd0};
                3:       limit = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
                default: limit = $urandom;
            endcase
            send_item(mode, key_word, limit, 1'b0, 32'd0);
            if (mode != MODE_UNUSED)
                sent++;
        end
        quiet = 1'b0;

        // Drop valid in the step of the last acceptance, then drain.
        s_tvalid <= 1'b0;
        while (awaited_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/rc4rg_pkg.sv
rtl/rc4rg_ram.sv
rtl/rc4rg_div.sv
rtl/rc4rg_datapath.sv
rtl/rc4rg_ctrl.sv
rtl/rc4_random_generator_top.sv
bench/tb_top.sv
